// File: sv/assert_macros.svh
// Assertion macros shared by the trie core modules.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/bxt_pkg.sv
// Shared types and constants of the binary trie max-XOR core.
// No dependencies; imported by the controller, the datapath and the top level.
package bxt_pkg;

    localparam int KEY_W          = 31;
    localparam int DATA_IN_W      = 32;
    localparam int DATA_OUT_W     = 64;
    localparam int USER_OUT_W     = 2;
    localparam int NODE_COUNT_DEF = 65536;
    localparam int KEY_BITS_DEF   = 31;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic start;     // request accepted: load key, set up walk
        logic step;      // walk one trie level
        logic load_out;  // move the finished result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip;      // request needs no walk (empty query or refused insert)
        logic last;      // current level is bit 0
        logic out_free;  // output register can take a result this cycle
    } stat_t;

endpackage

// File: sv/bxt_ctrl.sv
// Controller of the trie core: accepts a request, sequences the level walk
// and hands the result to the output register. Depends on bxt_pkg.
module bxt_ctrl import bxt_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

`include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    assign s_ready      = ready_reg;
    assign cmd.start    = ready_reg & s_valid;
    assign cmd.step     = (state_reg == ST_WALK) & ~stat.skip;
    assign cmd.load_out = (state_reg == ST_FINISH) & stat.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (ready_reg && s_valid) begin
                        state_reg <= ST_WALK;
                        ready_reg <= 1'b0;
                    end
                end
                ST_WALK: begin
                    if (stat.skip || stat.last) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (stat.out_free) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    `ASSERT_NXT(a_start_walks, cmd.start, state_reg == ST_WALK && !ready_reg)
    `ASSERT_IMP(a_ready_idle, ready_reg, state_reg == ST_IDLE)
    `ASSERT_NXT(a_finish_frees, cmd.load_out, ready_reg && !cmd.step)

endmodule

// File: sv/bxt_datapath.sv
// Datapath of the trie core: node memory, walk registers, bump allocator
// and output register. Depends on bxt_pkg; driven by bxt_ctrl commands.
module bxt_datapath import bxt_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output stat_t            stat,
    input  logic             op_in,
    input  logic [KEY_W-1:0] key_in,
    output logic [KEY_W-1:0] partner,
    output logic [KEY_W-1:0] xor_value,
    output logic             trie_empty,
    output logic             pool_full,
    output logic             m_valid,
    input  logic             m_ready
);

`include "assert_macros.svh"

    localparam int PTR_W      = $clog2(NODE_COUNT);
    localparam int LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int USE_W      = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int FREE_LIMIT = NODE_COUNT - 1 - KEY_BITS;
    localparam int NODE_LAST  = NODE_COUNT - 1;

    // One node: child pointer for bit 0 in [0], for bit 1 in [1]
    typedef logic [1:0][PTR_W-1:0] node_t;

    node_t mem [NODE_COUNT];
    node_t rd_data_reg;

    op_t                 op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] acc_reg;
    logic [KEY_BITS-1:0] acc_next;
    logic [LVL_W-1:0]    lvl_reg;
    logic [PTR_W-1:0]    node_reg;
    logic [PTR_W-1:0]    node_next;
    logic                fresh_reg;
    logic                skip_reg;
    logic [PTR_W-1:0]    free_reg;
    logic [PTR_W-1:0]    free_next;

    logic [KEY_W-1:0]    partner_reg;
    logic [KEY_W-1:0]    xor_reg;
    logic                empty_reg;
    logic                full_reg;
    logic                valid_reg;

    node_t               entry;
    node_t               wr_data;
    logic                wr_en;
    logic [PTR_W-1:0]    rd_addr;
    logic                bit_cur;
    logic                sel;
    logic                is_new;
    logic [PTR_W-1:0]    c_same;
    logic [PTR_W-1:0]    c_opp;
    logic                trie_is_empty;
    logic                pool_short;
    logic [KEY_BITS-1:0] partner_k;

    assign trie_is_empty = (free_reg == '0);
    assign pool_short    = (free_reg > PTR_W'(FREE_LIMIT));

    // Walk-new nodes and the root of an empty trie may be stale: read as zero
    assign entry   = fresh_reg ? node_t'('0) : rd_data_reg;
    assign bit_cur = key_reg[lvl_reg];
    assign c_same  = entry[bit_cur];
    assign c_opp   = entry[~bit_cur];
    assign is_new  = (c_same == '0);

    always_comb begin
        wr_data   = entry;
        free_next = free_reg;
        if (op_reg == OP_INSERT) begin
            sel       = bit_cur;
            node_next = is_new ? (free_reg + PTR_W'(1)) : c_same;
            free_next = is_new ? (free_reg + PTR_W'(1)) : free_reg;
        end else begin
            sel       = (c_opp != '0) ? ~bit_cur : bit_cur;
            node_next = entry[sel];
        end
        wr_data[bit_cur] = node_next;
        acc_next         = (acc_reg << 1) | KEY_BITS'(sel);
    end

    assign wr_en   = cmd.step & (op_reg == OP_INSERT) & is_new;
    assign rd_addr = cmd.start ? '0 : node_next;

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[node_reg] <= wr_data;
        end
    end

    // Walk registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg    <= op_t'(op_in);
            key_reg   <= KEY_BITS'(key_in[USE_W-1:0]);
            acc_reg   <= '0;
            lvl_reg   <= LVL_W'(KEY_BITS - 1);
            node_reg  <= '0;
            fresh_reg <= trie_is_empty;
            skip_reg  <= (op_t'(op_in) == OP_QUERY) ? trie_is_empty : pool_short;
        end else if (cmd.step) begin
            acc_reg   <= acc_next;
            lvl_reg   <= lvl_reg - LVL_W'(1);
            node_reg  <= node_next;
            fresh_reg <= (op_reg == OP_INSERT) & is_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg <= '0;
        end else if (cmd.step) begin
            free_reg <= free_next;
        end
    end

    // Output register
    assign partner_k = skip_reg ? key_reg : acc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (op_reg == OP_QUERY) begin
                partner_reg <= KEY_W'(partner_k);
                xor_reg     <= KEY_W'(key_reg ^ partner_k);
                empty_reg   <= skip_reg;
                full_reg    <= 1'b0;
            end else begin
                partner_reg <= '0;
                xor_reg     <= '0;
                empty_reg   <= 1'b0;
                full_reg    <= skip_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign stat.skip     = skip_reg;
    assign stat.last     = (lvl_reg == '0);
    assign stat.out_free = ~valid_reg | m_ready;

    assign partner    = partner_reg;
    assign xor_value  = xor_reg;
    assign trie_empty = empty_reg;
    assign pool_full  = full_reg;
    assign m_valid    = valid_reg;

    `ASSERT_IMP(a_free_bound, 1'b1, free_reg <= PTR_W'(NODE_LAST))
    `ASSERT_IMP(a_write_on_insert, wr_en, cmd.step && op_reg == OP_INSERT && !skip_reg)
    `ASSERT_NXT(a_free_hold, !wr_en, $stable(free_reg))

endmodule

// File: sv/binary_trie_max_xor_core.sv
// Binary trie max-XOR core: insert keys, query the stored key of largest XOR.
// A walked request takes one trie level per node-memory read; the next request
// is accepted only once the result has moved into the output register, which
// waits for a free result channel. Empty queries and refused inserts skip the walk.
// Reset (aresetn, synchronous, active low) empties the trie at once; there is
// no clearing pass, as nodes fresh from the allocator read as zero.
module binary_trie_max_xor_core import bxt_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_IN_W-1:0]  s_tdata,   // [30:0] key, [31] zero
    input  logic [0:0]            s_tuser,   // [0] opcode (0 insert, 1 query)
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_OUT_W-1:0] m_tdata,   // [30:0] partner, [61:31] xor_value, [63:62] zero
    output logic [USER_OUT_W-1:0] m_tuser    // [0] trie_empty, [1] pool_full
);

    cmd_t             cmd;
    stat_t            stat;
    logic [KEY_W-1:0] partner;
    logic [KEY_W-1:0] xor_value;
    logic             trie_empty;
    logic             pool_full;

    // Sequencer: accept, walk the levels, then hand over to the output register
    bxt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Node memory, allocator and result register
    bxt_datapath #(
        .NODE_COUNT (NODE_COUNT),
        .KEY_BITS   (KEY_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .op_in      (s_tuser[0]),
        .key_in     (s_tdata[KEY_W-1:0]),
        .partner    (partner),
        .xor_value  (xor_value),
        .trie_empty (trie_empty),
        .pool_full  (pool_full),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready)
    );

    // Pack the result; pad the top bits with zeros
    assign m_tdata = {(DATA_OUT_W - 2 * KEY_W)'(0), xor_value, partner};
    assign m_tuser = {pool_full, trie_empty};

endmodule
